@@ hw/rtl/rso2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randstrobe order-2 selector package
// Widths, sizes, register indexes and reset values shared by the selector core
// and its channel interfaces.
// ----------------------------------------------------------------------------
package rso2_pkg;

  // Payload widths.
  localparam int HASH_W  = 64;
  localparam int POS_W   = 32;
  localparam int FIELD_W = 6;

  // Hash ring. The ring is addressed by the low bits of a position, so its
  // depth is a power of two.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Number of low bits of the hash sum that take part in the minimum search.
  localparam int MATCH_BITS = 16;

  // Most results that one input word may cause.
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Configuration write channel.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_ID  = CFG_IDX_W'(3);

  localparam logic [FIELD_W-1:0] SHIFT_AMOUNT_RST = FIELD_W'(15);
  localparam logic [FIELD_W-1:0] WINDOW_START_RST = FIELD_W'(25);
  localparam logic [FIELD_W-1:0] WINDOW_END_RST   = FIELD_W'(50);

endpackage

@@ hw/rtl/rso2_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash input channel
// Carries one k-mer hash per word and a flag on the final hash of a sequence.
// ----------------------------------------------------------------------------
interface rso2_in_if
  import rso2_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;
  logic              last;

  modport source (output valid, output hash_value, output last, input ready);
  modport sink   (input valid, input hash_value, input last, output ready);
endinterface

@@ hw/rtl/rso2_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobemer result channel
// Carries one randstrobe per word: combined hash, both positions, run end.
// ----------------------------------------------------------------------------
interface rso2_out_if
  import rso2_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] strobemer_hash;
  logic [POS_W-1:0]  first_pos;
  logic [POS_W-1:0]  second_pos;
  logic              run_end;

  modport source (output valid, output strobemer_hash, output first_pos,
                  output second_pos, output run_end, input ready);
  modport sink   (input valid, input strobemer_hash, input first_pos,
                  input second_pos, input run_end, output ready);
endinterface

@@ hw/rtl/rso2_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data word to write there.
// ----------------------------------------------------------------------------
interface rso2_cfg_if
  import rso2_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/randstrobe_order2_selector_core.sv @@
`timescale 1ns / 1ps
// Flow: a word that releases no result goes from CHECK back to IDLE; each
//   result passes CHECK, HI, SCAN, FIN and OUT, waiting in OUT on a stall.
// Throughput: one word at a time; the single sum/compare unit walks the
//   window one stored hash per cycle.
// Reset: rst_ni clears the position counters and loads the default registers;
//   the hash ring is not cleared.
// ----------------------------------------------------------------------------
// Randstrobe order-2 selector core
// Keeps recent k-mer hashes in a ring memory and, for every first-strobe
// position, picks the earliest second strobe that minimizes the low bits of
// the hash sum, then emits the combined strobemer hash with both positions.
// ----------------------------------------------------------------------------
module randstrobe_order2_selector_core
  import rso2_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rso2_in_if.sink     in_i,
  rso2_out_if.source  out_o,
  rso2_cfg_if.sink    cfg_i
);

  // The sequencer. A word is written into the ring the cycle it is taken.
  // Then, for every first-strobe position that the word releases, CHECK
  // decides whether the position may go and fetches its hash, HI latches it,
  // SCAN runs the shared sum/compare unit over one candidate per cycle, FIN
  // forms the result and OUT holds it until the sink takes it.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_HI,
    S_SCAN,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Configuration registers. The sequence tag is accepted on the port but
  // has no effect on any result, so no storage is kept for it.
  logic [FIELD_W-1:0] shift_q, ws_q, we_q;
  logic [FIELD_W-1:0] we_eff;

  // Position bookkeeping.
  logic [POS_W-1:0]     recv_q, recv_d;
  logic [POS_W-1:0]     emit_q, emit_d;
  logic                 last_q, last_d;
  logic [RES_CNT_W-1:0] res_cnt_q, res_cnt_d;

  // Window scan.
  logic [FIELD_W-1:0]    end_q, end_d;
  logic [FIELD_W-1:0]    scan_off_q, scan_off_d;
  logic                  cand_first_q, cand_first_d;
  logic [HASH_W-1:0]     hi_q, hi_d;
  logic [MATCH_BITS-1:0] best_val_q, best_val_d;
  logic [FIELD_W-1:0]    best_off_q, best_off_d;
  logic [HASH_W-1:0]     best_hash_q, best_hash_d;

  // Result register.
  logic [HASH_W-1:0] res_hash_q, res_hash_d;
  logic [POS_W-1:0]  res_first_q, res_first_d;
  logic [POS_W-1:0]  res_second_q, res_second_d;
  logic              res_end_q, res_end_d;

  // Ring memory with one write and one registered read port.
  logic [HASH_W-1:0]  ring_mem [RING_DEPTH];
  logic [HASH_W-1:0]  rd_data_q;
  logic [RING_AW-1:0] rd_addr;
  logic [POS_W-1:0]   rd_pos;
  logic               in_fire;

  // Combinational helpers.
  logic [POS_W-1:0]      pos_gap;
  logic [MATCH_BITS-1:0] cand_sum;
  logic                  cand_take;
  logic [RES_CNT_W-1:0]  res_cnt_inc;

  // A position i may go once its window is present: with a = p - i, a plain
  // word needs the whole window, the final word accepts a clipped window that
  // holds at least two candidates, or the first of a window at most two wide.
  function automatic logic pos_ready(input logic [POS_W-1:0]   a,
                                     input logic               fin,
                                     input logic [FIELD_W-1:0] ws,
                                     input logic [FIELD_W-1:0] we);
    logic [POS_W-1:0] a_inc;
    logic [POS_W-1:0] ws_w;
    logic [POS_W-1:0] we_w;
    a_inc = a + POS_W'(1);
    ws_w  = POS_W'(ws);
    we_w  = POS_W'(we);
    if (fin) begin
      return (ws_w <= a) && ((we_w <= a_inc) || (ws_w + POS_W'(1) <= a));
    end else begin
      return we_w <= a;
    end
  endfunction

  // An inverted window collapses to its first candidate.
  assign we_eff = (we_q < ws_q) ? ws_q : we_q;

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign cfg_i.ready  = 1'b1;

  assign out_o.valid          = (state_q == S_OUT);
  assign out_o.strobemer_hash = res_hash_q;
  assign out_o.first_pos      = res_first_q;
  assign out_o.second_pos     = res_second_q;
  assign out_o.run_end        = res_end_q;

  assign pos_gap     = recv_q - emit_q;
  assign cand_sum    = hi_q[MATCH_BITS-1:0] + rd_data_q[MATCH_BITS-1:0];
  assign cand_take   = cand_first_q || (cand_sum < best_val_q);
  assign res_cnt_inc = res_cnt_q + RES_CNT_W'(1);

  // Read address: the first-strobe hash in CHECK, the first candidate in HI,
  // and the candidate after the one being compared in SCAN.
  always_comb begin
    case (state_q)
      S_HI:    rd_pos = emit_q + POS_W'(ws_q);
      S_SCAN:  rd_pos = emit_q + POS_W'(scan_off_q) + POS_W'(1);
      default: rd_pos = emit_q;
    endcase
  end
  assign rd_addr = rd_pos[RING_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_mem[recv_q[RING_AW-1:0]] <= in_i.hash_value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_mem[rd_addr];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d      = state_q;
    recv_d       = recv_q;
    emit_d       = emit_q;
    last_d       = last_q;
    res_cnt_d    = res_cnt_q;
    end_d        = end_q;
    scan_off_d   = scan_off_q;
    cand_first_d = cand_first_q;
    hi_d         = hi_q;
    best_val_d   = best_val_q;
    best_off_d   = best_off_q;
    best_hash_d  = best_hash_q;
    res_hash_d   = res_hash_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    res_end_d    = res_end_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d    = in_i.last;
          res_cnt_d = '0;
          state_d   = S_CHECK;
        end
      end

      S_CHECK: begin
        if ((res_cnt_q < RES_CNT_W'(MAX_RESULTS)) &&
            pos_ready(pos_gap, last_q, ws_q, we_eff)) begin
          // The window is clipped at the newest position.
          end_d   = (pos_gap < POS_W'(we_eff)) ? pos_gap[FIELD_W-1:0] : we_eff;
          state_d = S_HI;
        end else begin
          // Nothing more to emit for this word.
          if (last_q) begin
            recv_d = '0;
            emit_d = '0;
          end else begin
            recv_d = recv_q + POS_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      S_HI: begin
        hi_d         = rd_data_q;
        scan_off_d   = ws_q;
        cand_first_d = 1'b1;
        state_d      = S_SCAN;
      end

      S_SCAN: begin
        // Strict less-than keeps the earliest candidate on a tie.
        if (cand_take) begin
          best_val_d  = cand_sum;
          best_off_d  = scan_off_q;
          best_hash_d = rd_data_q;
        end
        cand_first_d = 1'b0;
        if (scan_off_q == end_q) begin
          state_d = S_FIN;
        end else begin
          scan_off_d = scan_off_q + FIELD_W'(1);
        end
      end

      S_FIN: begin
        res_hash_d   = (hi_q << shift_q) ^ best_hash_q;
        res_first_d  = emit_q;
        res_second_d = emit_q + POS_W'(best_off_q);
        // Look one position ahead so that the run end rides on this word.
        res_end_d    = !((res_cnt_inc < RES_CNT_W'(MAX_RESULTS)) &&
                         pos_ready(pos_gap - POS_W'(1), last_q, ws_q, we_eff));
        emit_d       = emit_q + POS_W'(1);
        res_cnt_d    = res_cnt_inc;
        state_d      = S_OUT;
      end

      S_OUT: begin
        if (out_o.ready) begin
          if (res_end_q) begin
            if (last_q) begin
              recv_d = '0;
              emit_d = '0;
            end else begin
              recv_d = recv_q + POS_W'(1);
            end
            state_d = S_IDLE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      recv_q       <= '0;
      emit_q       <= '0;
      last_q       <= 1'b0;
      res_cnt_q    <= '0;
      end_q        <= '0;
      scan_off_q   <= '0;
      cand_first_q <= 1'b0;
      hi_q         <= '0;
      best_val_q   <= '0;
      best_off_q   <= '0;
      best_hash_q  <= '0;
      res_hash_q   <= '0;
      res_first_q  <= '0;
      res_second_q <= '0;
      res_end_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      recv_q       <= recv_d;
      emit_q       <= emit_d;
      last_q       <= last_d;
      res_cnt_q    <= res_cnt_d;
      end_q        <= end_d;
      scan_off_q   <= scan_off_d;
      cand_first_q <= cand_first_d;
      hi_q         <= hi_d;
      best_val_q   <= best_val_d;
      best_off_q   <= best_off_d;
      best_hash_q  <= best_hash_d;
      res_hash_q   <= res_hash_d;
      res_first_q  <= res_first_d;
      res_second_q <= res_second_d;
      res_end_q    <= res_end_d;
    end
  end

  // Configuration registers. User writes only while core is idle; unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_AMOUNT_RST;
      ws_q    <= WINDOW_START_RST;
      we_q    <= WINDOW_END_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_SHIFT_AMOUNT: shift_q <= cfg_i.data[FIELD_W-1:0];
        REG_WINDOW_START: ws_q    <= cfg_i.data[FIELD_W-1:0];
        REG_WINDOW_END:   we_q    <= cfg_i.data[FIELD_W-1:0];
        REG_SEQUENCE_ID:  begin
          // Software tag only; nothing in the datapath depends on it.
        end
        default: begin
        end
      endcase
    end
  end

  // The core never takes a new word while a result is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken while a result is pending");

  // Every second strobe lies inside the configured window of its first strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.second_pos - out_o.first_pos) >= POS_W'(ws_q)) &&
                    ((out_o.second_pos - out_o.first_pos) <= POS_W'(we_eff)))
    else $error("second strobe outside its window");

  // The scan never runs past the clipped end of the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_off_q <= end_q) && (scan_off_q >= ws_q))
    else $error("scan offset out of range");

  // No word causes more results than the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count above cap");

  // A result that ends its run returns the core to idle once it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.run_end) |=> in_i.ready)
    else $error("core not idle after the last result of a word");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randstrobe order-2 selector testbench
// Streams k-mer hash words into the selector core under several register
// settings. A behavioral predictor works out every expected strobemer, and a
// checker compares each result word field by field, in order, while both sides
// of the core idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rso2_pkg::*;

  // One expected result word on the strobemer channel.
  typedef struct {
    logic [HASH_W-1:0] strobemer_hash;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  second_pos;
    logic              run_end;
  } strobe_t;

  // Shapes of generated hash words. The corner and narrow shapes squeeze the
  // low bits into a few values so that ties and saturated sums turn up often.
  typedef enum int {HASH_RANDOM, HASH_CORNER, HASH_NARROW} hash_style_e;

  logic clk_i;
  logic rst_ni;

  rso2_in_if  hash_ch ();
  rso2_out_if strobe_ch ();
  rso2_cfg_if reg_ch ();

  randstrobe_order2_selector_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (hash_ch),
    .out_o  (strobe_ch),
    .cfg_i  (reg_ch)
  );

  // Predictor state: its own copy of the hash ring, the position counters and
  // the registers, kept in step with every accepted hash and register word.
  logic [HASH_W-1:0]  pred_ring [RING_DEPTH];
  logic [POS_W-1:0]   seq_pos;
  logic [POS_W-1:0]   emit_pos;
  logic [FIELD_W-1:0] shift_r;
  logic [FIELD_W-1:0] win_start_r;
  logic [FIELD_W-1:0] win_end_r;
  logic [31:0]        seq_tag_r;

  strobe_t expected_strobes[$];

  int fault_count    = 0;
  int hashes_sent    = 0;
  int sequences_sent = 0;
  int strobes_seen   = 0;
  int reg_writes     = 0;

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit no_gaps      = 1'b0;
  int stall_cycles = 0;

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Hard limit on the run. The slowest legal run has every word releasing the
  // full 64 results, each walking 64 candidates and waiting out receiver
  // stalls, which stays well below this bound.
  initial begin
    #40_000_000;
    $display("FAIL randstrobe_order2_selector_core");
    $finish;
  end

  // Records one failure. Only the first ten are printed.
  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Register write as the core sees it. Only the low bits of a field count,
  // and an index past the register list changes nothing.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SHIFT_AMOUNT: shift_r     = data[FIELD_W-1:0];
      REG_WINDOW_START: win_start_r = data[FIELD_W-1:0];
      REG_WINDOW_END:   win_end_r   = data[FIELD_W-1:0];
      REG_SEQUENCE_ID:  seq_tag_r   = data;
      default: ;
    endcase
  endfunction

  // Stores one hash word in the predictor's ring and queues every strobemer
  // that it releases. A plain word releases each first strobe whose full
  // window is now present. The final word of a sequence flushes the tail with
  // windows clipped at the end of the sequence. The release test runs on
  // 32-bit position differences, so with a zero window start the difference
  // can wrap and the run stops only at the result cap.
  function automatic void predict_strobes(input logic [HASH_W-1:0] hv,
                                          input logic is_last);
    logic [POS_W-1:0]      p, i, a, lim, ws, we, off, best_off, slot;
    logic [HASH_W-1:0]     hi, hj, best_hash, sum_full;
    logic [MATCH_BITS-1:0] best_sum;
    logic                  fire, have;
    strobe_t               batch [MAX_RESULTS];
    int                    n;
    p  = seq_pos;
    ws = POS_W'(win_start_r);
    // An inverted window shrinks to its start, a single candidate.
    we = (win_end_r < win_start_r) ? ws : POS_W'(win_end_r);
    n  = 0;
    pred_ring[p[RING_AW-1:0]] = hv;
    while (n < MAX_RESULTS) begin
      i = emit_pos;
      a = p - i;
      if (is_last) begin
        fire = (ws <= a) && ((we <= a + 32'd1) || (ws + 32'd1 <= a));
      end else begin
        fire = (we <= a);
      end
      if (!fire) break;
      lim       = (we < a) ? we : a;
      hi        = pred_ring[i[RING_AW-1:0]];
      have      = 1'b0;
      best_off  = ws;
      best_hash = '0;
      best_sum  = '0;
      // The earliest candidate wins ties; the first one is always taken, even
      // when its masked sum is all ones.
      for (off = ws; off <= lim; off++) begin
        slot     = i + off;
        hj       = pred_ring[slot[RING_AW-1:0]];
        sum_full = hi + hj;
        if (!have || sum_full[MATCH_BITS-1:0] < best_sum) begin
          have      = 1'b1;
          best_sum  = sum_full[MATCH_BITS-1:0];
          best_off  = off;
          best_hash = hj;
        end
      end
      batch[n].strobemer_hash = (hi << shift_r) ^ best_hash;
      batch[n].first_pos      = i;
      batch[n].second_pos     = i + best_off;
      batch[n].run_end        = 1'b0;
      n++;
      emit_pos = i + 32'd1;
    end
    for (int k = 0; k < n; k++) begin
      batch[k].run_end = (k == n - 1);
      expected_strobes.insert(expected_strobes.size(), batch[k]);
    end
    if (is_last) begin
      seq_pos  = '0;
      emit_pos = '0;
    end else begin
      seq_pos = p + 32'd1;
    end
  endfunction

  // Builds one hash word of the given shape.
  function automatic logic [HASH_W-1:0] make_hash(input hash_style_e style);
    logic [HASH_W-1:0] h;
    h = {$urandom, $urandom};
    case (style)
      HASH_CORNER: begin
        case ($urandom_range(0, 3))
          0:       h[15:0] = 16'h0000;
          1:       h[15:0] = 16'h7FFF;
          2:       h[15:0] = 16'h8000;
          default: h[15:0] = 16'hFFFF;
        endcase
      end
      HASH_NARROW: h[15:0] = 16'($urandom_range(0, 3));
      default: ;
    endcase
    return h;
  endfunction

  // Offers one hash word and waits until the core takes it. Before the word
  // the sender may pause; during a pause valid is low. Valid stays high from
  // one word into the next when there is no pause.
  task automatic send_hash(input logic [HASH_W-1:0] hv, input logic is_last);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 33) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      hash_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hash_ch.valid      <= 1'b1;
    hash_ch.hash_value <= hv;
    hash_ch.last       <= is_last;
    do @(posedge clk_i); while (!hash_ch.ready);
    predict_strobes(hv, is_last);
    hashes_sent++;
    if (is_last) sequences_sent++;
  endtask

  // Sends a whole sequence; its final word carries the last flag.
  task automatic send_sequence(input int len, input hash_style_e style);
    for (int k = 0; k < len; k++) begin
      send_hash(make_hash(style), k == len - 1);
    end
  endtask

  // Drops the input valid, then waits until every expected strobemer has come
  // back and a word that released nothing has surely been retired.
  task automatic wait_idle();
    @(negedge clk_i);
    hash_ch.valid <= 1'b0;
    while (expected_strobes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // One register write over the configuration channel. Only called while the
  // core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk_i); while (!reg_ch.ready);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    reg_ch.valid <= 1'b0;
  endtask

  // Fills the unused upper data bits of a 6-bit field with junk half the time.
  function automatic logic [CFG_DATA_W-1:0] pad_field(input int v);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? ($urandom & ~32'h3F) : '0;
    return junk | CFG_DATA_W'(v & 63);
  endfunction

  task automatic set_windows(input int shift, input int ws, input int we);
    write_reg(REG_SHIFT_AMOUNT, pad_field(shift));
    write_reg(REG_WINDOW_START, pad_field(ws));
    write_reg(REG_WINDOW_END,   pad_field(we));
  endtask

  // Receiver: drops ready at random, holds it high during quiet stretches,
  // and holds it low for as many cycles as a pressure test asks.
  initial begin
    strobe_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_cycles > 0) begin
        strobe_ch.ready <= 1'b0;
        stall_cycles--;
      end else if (no_gaps) begin
        strobe_ch.ready <= 1'b1;
      end else begin
        strobe_ch.ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Checker: every accepted strobemer word is held against the oldest
  // expectation. A word with nothing expected is a failure on its own.
  strobe_t want;
  always @(posedge clk_i) begin
    if (rst_ni && strobe_ch.valid && strobe_ch.ready) begin
      strobes_seen++;
      if (expected_strobes.size() == 0) begin
        note_fault($sformatf("unexpected strobemer first_pos=%0d second_pos=%0d",
                             strobe_ch.first_pos, strobe_ch.second_pos));
      end else begin
        want = expected_strobes[0];
        expected_strobes.delete(0);
        if (strobe_ch.strobemer_hash !== want.strobemer_hash) begin
          note_fault($sformatf("first_pos %0d strobemer_hash expected %h got %h",
                               want.first_pos, want.strobemer_hash,
                               strobe_ch.strobemer_hash));
        end
        if (strobe_ch.first_pos !== want.first_pos) begin
          note_fault($sformatf("first_pos expected %0d got %0d",
                               want.first_pos, strobe_ch.first_pos));
        end
        if (strobe_ch.second_pos !== want.second_pos) begin
          note_fault($sformatf("first_pos %0d second_pos expected %0d got %0d",
                               want.first_pos, want.second_pos,
                               strobe_ch.second_pos));
        end
        if (strobe_ch.run_end !== want.run_end) begin
          note_fault($sformatf("first_pos %0d run_end expected %b got %b",
                               want.first_pos, want.run_end, strobe_ch.run_end));
        end
      end
    end
  end

  // At the reset settings no window fits into a six-word sequence, so nothing
  // comes out and the position counters must still clear on the last word.
  task automatic test_short_sequence();
    send_hash('0, 1'b0);
    send_hash('1, 1'b0);
    send_hash(64'h8000_0000_0000_0001, 1'b0);
    send_hash(64'h0000_0000_0000_FFFF, 1'b0);
    send_hash(make_hash(HASH_RANDOM), 1'b0);
    send_hash('1, 1'b1);
    wait_idle();
  endtask

  // Writes every register, including an index past the list, then runs a
  // small window with the widest shift over extreme and tying hash words.
  task automatic test_register_writes();
    write_reg(REG_SEQUENCE_ID, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(4), 32'h0000_0007);
    write_reg('1, 32'h0000_0001);
    set_windows(63, 2, 4);
    send_hash('0, 1'b0);
    send_hash('1, 1'b0);
    send_hash(64'h0000_0000_0000_8000, 1'b0);
    send_hash(64'h8000_0000_0000_7FFF, 1'b0);
    send_hash(64'hFFFF_FFFF_FFFF_0000, 1'b0);
    send_hash(64'h0123_4567_89AB_CDEF, 1'b0);
    send_hash('0, 1'b0);
    send_hash('1, 1'b0);
    send_hash(64'h5555_AAAA_5555_AAAA, 1'b1);
    wait_idle();
    write_reg(REG_SEQUENCE_ID, 32'h0000_0000);
  endtask

  // A window end below its start leaves one candidate at the start offset.
  // With an odd offset and alternating low halves the masked sum saturates.
  task automatic test_inverted_window();
    logic [HASH_W-1:0] h;
    set_windows(0, 5, 2);
    for (int k = 0; k < 9; k++) begin
      h = make_hash(HASH_RANDOM);
      h[15:0] = (k % 2 == 0) ? 16'h7FFF : 16'h8000;
      send_hash(h, k == 8);
    end
    wait_idle();
  endtask

  // Picks a new register setting: the reset values, the widest and the
  // narrowest windows, an inverted window, or a random small one.
  task automatic pick_random_windows();
    int ws;
    case ($urandom_range(0, 9))
      0: set_windows(SHIFT_AMOUNT_RST, WINDOW_START_RST, WINDOW_END_RST);
      1: set_windows($urandom_range(0, 63), 1, 63);
      2: set_windows(32, 62, 63);
      3: set_windows(1, 1, 2);
      4: begin
        ws = $urandom_range(3, 12);
        set_windows($urandom_range(0, 63), ws, $urandom_range(0, ws - 1));
      end
      default: begin
        ws = $urandom_range(1, 10);
        set_windows($urandom_range(0, 63), ws, $urandom_range(ws + 1, ws + 14));
      end
    endcase
    if ($urandom_range(0, 4) == 0) write_reg(REG_SEQUENCE_ID, $urandom);
  endtask

  // Mostly complete sequences long enough to fill their windows, with random
  // content; the rest end before any window fits, or are a lone last word.
  task automatic test_random_sequences();
    int          start_count, len, we_eff;
    hash_style_e style;
    start_count = hashes_sent;
    while (hashes_sent - start_count < 50) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        pick_random_windows();
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      style   = hash_style_e'($urandom_range(0, 2));
      we_eff  = (win_end_r < win_start_r) ? int'(win_start_r) : int'(win_end_r);
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, win_start_r);
        2:       len = 1;
        default: len = we_eff + $urandom_range(1, 12);
      endcase
      send_sequence(len, style);
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back-to-back words, so the core fills up and stalls its input.
  task automatic test_output_backpressure();
    set_windows(7, 1, 3);
    no_gaps      = 1'b1;
    stall_cycles = 300;
    send_sequence(25, HASH_NARROW);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // A zero window start lets a position pick itself. With a window end of
  // zero, and on a last word with an end of one, the position difference
  // wraps and every word runs into the result cap. Those runs read ring
  // entries ahead of the sequence, so the whole ring is written first.
  task automatic test_result_cap();
    set_windows(9, 3, 10);
    send_sequence(RING_DEPTH, HASH_RANDOM);
    wait_idle();
    set_windows(5, 0, 0);
    send_sequence(4, HASH_CORNER);
    wait_idle();
    set_windows(40, 0, 1);
    send_sequence(3, HASH_NARROW);
    wait_idle();
    set_windows(33, 0, 6);
    send_sequence(8, HASH_NARROW);
    wait_idle();
  endtask

  // Main sequence: reset once, then the tests in turn, then the verdict.
  initial begin
    rst_ni             = 1'b0;
    hash_ch.valid      = 1'b0;
    hash_ch.hash_value = '0;
    hash_ch.last       = 1'b0;
    reg_ch.valid       = 1'b0;
    reg_ch.index       = '0;
    reg_ch.data        = '0;
    for (int k = 0; k < RING_DEPTH; k++) pred_ring[k] = '0;
    seq_pos     = '0;
    emit_pos    = '0;
    shift_r     = SHIFT_AMOUNT_RST;
    win_start_r = WINDOW_START_RST;
    win_end_r   = WINDOW_END_RST;
    seq_tag_r   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_sequence();
    test_register_writes();
    test_inverted_window();
    test_random_sequences();
    test_output_backpressure();
    test_result_cap();
    wait_idle();

    $display("Run covered %0d hash words in %0d sequences and %0d register writes.",
             hashes_sent, sequences_sent, reg_writes);
    $display("%0d strobemer words checked, %0d failures.", strobes_seen, fault_count);
    if (fault_count == 0) begin
      $display("PASS randstrobe_order2_selector_core");
    end else begin
      $display("FAIL randstrobe_order2_selector_core");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rso2_pkg.sv
hw/rtl/rso2_in_if.sv
hw/rtl/rso2_out_if.sv
hw/rtl/rso2_cfg_if.sv
hw/rtl/randstrobe_order2_selector_core.sv
sim/testbench.sv
